// ===== src/ppid_pkg.sv =====
// Shared types, constants and register codes for the preset position PID block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package ppid_pkg;

   localparam int unsigned SETTLE_TIMEOUT_MS = 5000;
   localparam int unsigned SETTLE_BAND       = 10;

   localparam int unsigned GAIN_W   = 32;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned ERR_W    = POS_W + 1;
   localparam int unsigned DIFF_W   = ERR_W + 1;
   localparam int unsigned SUM_W    = 32;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned DRIVE_W  = 16;
   localparam int unsigned FRAC_W   = 24;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [GAIN_W-1:0] GAIN_P_RST = 32'd838861;
   localparam logic [GAIN_W-1:0] GAIN_I_RST = 32'd168;
   localparam logic [GAIN_W-1:0] GAIN_D_RST = 32'd167772;
   localparam logic [POS_W-1:0]  PRESET0_RST = 12'd350;
   localparam logic [POS_W-1:0]  PRESET1_RST = 12'd1000;
   localparam logic [POS_W-1:0]  PRESET2_RST = 12'd3440;
   localparam logic [POS_W-1:0]  PRESET3_RST = 12'd1000;
   localparam logic [POS_W-1:0]  SAFE_ANGLE_RST = 12'd600;

   localparam logic [1:0] PRESET_REST  = 2'd0;
   localparam logic [1:0] PRESET_CLEAR = 2'd3;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_MOVE   = 2'd1,
      FUNC_AVOID  = 2'd2,
      FUNC_RETURN = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P       = 8'd0,
      REG_GAIN_I       = 8'd1,
      REG_GAIN_D       = 8'd2,
      REG_PRESET_ZERO  = 8'd3,
      REG_PRESET_ONE   = 8'd4,
      REG_PRESET_TWO   = 8'd5,
      REG_PRESET_THREE = 8'd6,
      REG_SAFE_ANGLE   = 8'd7
   } reg_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0]           gain_p;
      logic [GAIN_W-1:0]           gain_i;
      logic [GAIN_W-1:0]           gain_d;
      logic [3:0][POS_W-1:0]       preset;
      logic [POS_W-1:0]            safe_angle;
   } cfg_type;

   // Result of the front stage, consumed by the multiply-accumulate stage.
   typedef struct packed {
      logic                        drive_valid;
      logic signed [ERR_W-1:0]     err;
      logic signed [SUM_W-1:0]     err_sum;
      logic signed [DIFF_W-1:0]    err_diff;
      logic                        settled;
      logic                        safe_to_shoot;
      logic [1:0]                  preset;
   } front_type;

endpackage

// ===== src/ppid_front.sv =====
// Front stage: controller state, command decode, error, integral and flags.
// Depends on ppid_pkg.
`timescale 1ns / 1ps

module ppid_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    func,
   input  logic [ppid_pkg::POS_W-1:0]    pot_reading,
   input  logic [1:0]                    preset_index,
   input  logic [ppid_pkg::TIME_W-1:0]   now_ms,
   input  ppid_pkg::cfg_type             cfg,
   output ppid_pkg::front_type           front
);
   import ppid_pkg::*;

   logic [POS_W-1:0]         target_pos_ff, target_pos_in;
   logic [1:0]               target_preset_ff, target_preset_in;
   logic signed [SUM_W-1:0]  err_sum_ff, err_sum_in;
   logic signed [ERR_W-1:0]  last_err_ff, last_err_in;
   logic [TIME_W-1:0]        start_ff, start_in;

   logic                     go;
   logic [1:0]               go_idx;
   logic                     is_sample;
   logic signed [ERR_W-1:0]  err;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_sat;
   logic signed [ERR_W-1:0]  err_after;
   logic [ERR_W-1:0]         err_mag;
   logic                     timed_out;

   always_comb begin
      go        = 1'b0;
      go_idx    = preset_index;
      is_sample = 1'b0;
      unique case (func_type'(func))
         FUNC_SAMPLE: is_sample = 1'b1;
         FUNC_MOVE: go = 1'b1;
         FUNC_AVOID: begin
            go     = (target_preset_ff == PRESET_REST);
            go_idx = PRESET_CLEAR;
         end
         FUNC_RETURN: begin
            go     = (target_preset_ff == PRESET_CLEAR);
            go_idx = PRESET_REST;
         end
         default: is_sample = 1'b0;
      endcase
   end

   assign err      = signed'({1'b0, pot_reading}) - signed'({1'b0, target_pos_ff});
   assign sum_wide = (SUM_W+1)'(err_sum_ff) + (SUM_W+1)'(err);

   // Saturate the integral to the signed 32-bit range.
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      target_pos_in    = target_pos_ff;
      target_preset_in = target_preset_ff;
      err_sum_in       = err_sum_ff;
      last_err_in      = last_err_ff;
      start_in         = start_ff;
      if (is_sample) begin
         err_sum_in  = sum_sat;
         last_err_in = err;
      end
      if (go) begin
         target_preset_in = go_idx;
         target_pos_in    = cfg.preset[go_idx];
         err_sum_in       = '0;
         start_in         = now_ms;
      end
   end

   // Flags use the state after this item's update.
   assign err_after = signed'({1'b0, pot_reading}) - signed'({1'b0, target_pos_in});
   assign err_mag   = err_after[ERR_W-1] ? ERR_W'(-err_after) : ERR_W'(err_after);
   assign timed_out = (now_ms - start_in) > TIME_W'(SETTLE_TIMEOUT_MS);

   always_comb begin
      front.drive_valid   = is_sample;
      front.err           = err;
      front.err_sum       = sum_sat;
      front.err_diff      = DIFF_W'(err) - DIFF_W'(last_err_ff);
      front.settled       = (err_mag < ERR_W'(SETTLE_BAND)) || timed_out;
      front.safe_to_shoot = (pot_reading > cfg.safe_angle) || timed_out;
      front.preset        = target_preset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_pos_ff    <= PRESET0_RST;
         target_preset_ff <= PRESET_REST;
         err_sum_ff       <= '0;
         last_err_ff      <= '0;
         start_ff         <= '0;
      end else if (accept) begin
         target_pos_ff    <= target_pos_in;
         target_preset_ff <= target_preset_in;
         err_sum_ff       <= err_sum_in;
         last_err_ff      <= last_err_in;
         start_ff         <= start_in;
      end
   end

endmodule

// ===== src/ppid_mac.sv =====
// Gain stage: three parallel products with Q8.24 gains, integral clamp, sum, scale, negate and saturate;
// drive is zero for command items. Depends on ppid_pkg.
`timescale 1ns / 1ps

module ppid_mac (
   input  ppid_pkg::front_type                 front,
   input  ppid_pkg::cfg_type                   cfg,
   output logic signed [ppid_pkg::DRIVE_W-1:0] drive
);
   import ppid_pkg::*;

   localparam int unsigned ACC_W = 64;
   localparam logic signed [ACC_W-1:0] I_LIMIT = 64'sd1 <<< 61;
   localparam logic signed [ACC_W-1:0] DRIVE_MAX = 64'sd32767;
   localparam logic signed [ACC_W-1:0] DRIVE_MIN = -64'sd32768;
   localparam logic signed [ACC_W-1:0] ROUND_ADJ = (64'sd1 <<< FRAC_W) - 64'sd1;

   logic signed [ERR_W+GAIN_W:0]   p_prod;
   logic signed [SUM_W+GAIN_W:0]   i_prod;
   logic signed [DIFF_W+GAIN_W:0]  d_prod;
   logic signed [ACC_W-1:0]        i_clamped;
   logic signed [ACC_W-1:0]        total;
   logic signed [ACC_W-1:0]        quot;
   logic signed [ACC_W-1:0]        neg;

   assign p_prod = front.err * signed'({1'b0, cfg.gain_p});
   assign i_prod = front.err_sum * signed'({1'b0, cfg.gain_i});
   assign d_prod = front.err_diff * signed'({1'b0, cfg.gain_d});

   always_comb begin
      if (i_prod > (SUM_W+GAIN_W+1)'(I_LIMIT)) begin
         i_clamped = I_LIMIT;
      end else if (i_prod < (SUM_W+GAIN_W+1)'(-I_LIMIT)) begin
         i_clamped = -I_LIMIT;
      end else begin
         i_clamped = ACC_W'(i_prod);
      end
   end

   assign total = ACC_W'(p_prod) + i_clamped + ACC_W'(d_prod);
   // Truncate toward zero: bias negative sums before the arithmetic shift.
   assign quot  = (total[ACC_W-1] ? total + ROUND_ADJ : total) >>> FRAC_W;
   assign neg   = -quot;

   always_comb begin
      if (!front.drive_valid) begin
         drive = '0;
      end else if (neg > DRIVE_MAX) begin
         drive = DRIVE_W'(DRIVE_MAX);
      end else if (neg < DRIVE_MIN) begin
         drive = DRIVE_W'(DRIVE_MIN);
      end else begin
         drive = DRIVE_W'(neg);
      end
   end

endmodule

// ===== src/preset_position_pid_top.sv =====
// Top level of the preset position PID controller: register file, handshake and pipeline.
// Depends on ppid_pkg, ppid_front and ppid_mac.
`timescale 1ns / 1ps
// Path: an accepted item is registered in the stage register and then in the output
// register, which raises rsp_valid; a stalled output holds it in the stage register.
// Throughput: one item per cycle while the output drains; the front stage state updates at each accept.
// A full output register with rsp_ready low stalls the stage register, then the input.
// Reset (synchronous, active high) restores register defaults, target preset 0
// at 350, zero integral, last error and start time, and empties the pipeline.

module preset_position_pid_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_wdata,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [ppid_pkg::POS_W-1:0]          req_pot_reading,
   input  logic [1:0]                          req_preset_index,
   input  logic [ppid_pkg::TIME_W-1:0]         req_now_ms,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ppid_pkg::DRIVE_W-1:0] rsp_drive,
   output logic                                rsp_drive_valid,
   output logic                                rsp_settled,
   output logic                                rsp_safe_to_shoot,
   output logic [1:0]                          rsp_current_preset
);
   import ppid_pkg::*;

   cfg_type   cfg_ff;
   front_type front;
   front_type stage_ff;
   logic      stage_valid_ff;
   logic      out_valid_ff;
   logic      stage_adv;
   logic      accept;
   logic signed [DRIVE_W-1:0] drive;

   // Configuration writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= GAIN_P_RST;
         cfg_ff.gain_i     <= GAIN_I_RST;
         cfg_ff.gain_d     <= GAIN_D_RST;
         cfg_ff.preset[0]  <= PRESET0_RST;
         cfg_ff.preset[1]  <= PRESET1_RST;
         cfg_ff.preset[2]  <= PRESET2_RST;
         cfg_ff.preset[3]  <= PRESET3_RST;
         cfg_ff.safe_angle <= SAFE_ANGLE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GAIN_P:       cfg_ff.gain_p     <= csr_wdata;
            REG_GAIN_I:       cfg_ff.gain_i     <= csr_wdata;
            REG_GAIN_D:       cfg_ff.gain_d     <= csr_wdata;
            REG_PRESET_ZERO:  cfg_ff.preset[0]  <= csr_wdata[POS_W-1:0];
            REG_PRESET_ONE:   cfg_ff.preset[1]  <= csr_wdata[POS_W-1:0];
            REG_PRESET_TWO:   cfg_ff.preset[2]  <= csr_wdata[POS_W-1:0];
            REG_PRESET_THREE: cfg_ff.preset[3]  <= csr_wdata[POS_W-1:0];
            REG_SAFE_ANGLE:   cfg_ff.safe_angle <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the stage register whenever the output slot is free or draining.
   assign stage_adv = !out_valid_ff || rsp_ready;
   assign req_ready = !stage_valid_ff || stage_adv;
   assign accept    = req_valid && req_ready;

   // Controller state updates at the accept edge, so the next item sees it at once.
   ppid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (req_func),
      .pot_reading  (req_pot_reading),
      .preset_index (req_preset_index),
      .now_ms       (req_now_ms),
      .cfg          (cfg_ff),
      .front        (front)
   );

   ppid_mac u_mac (
      .front (stage_ff),
      .cfg   (cfg_ff),
      .drive (drive)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= front;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_adv) begin
         out_valid_ff <= stage_valid_ff;
      end
   end

   // Hold the result until it is taken.
   always_ff @(posedge clock) begin
      if (stage_adv && stage_valid_ff) begin
         rsp_drive          <= drive;
         rsp_drive_valid    <= stage_ff.drive_valid;
         rsp_settled        <= stage_ff.settled;
         rsp_safe_to_shoot  <= stage_ff.safe_to_shoot;
         rsp_current_preset <= stage_ff.preset;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_cmd_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_valid) |-> (rsp_drive == '0))
      else $error("command item carries a nonzero drive");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage_valid_ff)
      else $error("accepted item lost before the stage register");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while pipeline is full and stalled");

   a_stage_drains: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && (!rsp_valid || rsp_ready)) |=> rsp_valid)
      else $error("stage item did not reach the output register");

endmodule
